FILE: design/cmw_pkg.sv
// Shared types, codes and helpers for the column melt wipe offsets unit.
// No dependencies; imported by column_melt_wipe_offsets_unit.
`timescale 1ns / 1ps
`default_nettype none

package cmw_pkg;

  // Fixed field widths
  localparam int CMD_W     = 2;
  localparam int COL_W     = 9;
  localparam int ROW_W     = 10;
  localparam int RND_W     = 8;
  localparam int TICK_W    = 4;
  localparam int CFG_W     = 10;
  localparam int CFG_IDX_W = 2;

  // Parameter defaults
  localparam int MAX_COLUMNS_DEF  = 512;
  localparam int OFFSET_WIDTH_DEF = 11;

  // Configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;
  localparam logic [CFG_W-1:0]     COLUMN_COUNT_RST  = 10'd320;
  localparam logic [CFG_W-1:0]     SCREEN_HEIGHT_RST = 10'd200;

  typedef enum logic [CMD_W-1:0] {
    CMD_SEED  = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN
  } state_e;

  // Byte mod 3: base-4 digits all weigh 1 mod 3, so fold them and reduce.
  function automatic logic [1:0] mod3_byte(input logic [RND_W-1:0] b);
    logic [3:0] s;
    s = 4'(b[1:0]) + 4'(b[3:2]) + 4'(b[5:4]) + 4'(b[7:6]);
    if (s >= 4'd9) s = s - 4'd9;
    if (s >= 4'd6) s = s - 4'd6;
    if (s >= 4'd3) s = s - 4'd3;
    return s[1:0];
  endfunction

endpackage

`default_nettype wire

FILE: design/column_melt_wipe_offsets_unit.sv
// Column melt wipe offsets unit: per-column drop offsets of a screen melt.
// Depends on cmw_pkg (commands, states, register codes, mod 3 helper).
//
// Usage
//   Input channel (in_valid_i/in_ready_o) carries one command beat:
//     seed  - write one column offset from random_byte_i (chained offsets),
//     tick  - advance every active column tick_count_i melt steps,
//     query - return the pixel source (frame, row) for column_i/row_i.
//   Every input beat yields exactly one output beat (out_valid_o/out_ready_i)
//   holding done_res_o, from_end_o and source_row_o; unused fields are zero.
//   Config channel (cfg_valid_i/cfg_ready_o) is always ready; write only when
//   the unit is idle. Index 0 column_count, index 1 screen_height.
// Throughput
//   Seed, query and unknown commands: the beat is staged at the accepting edge
//   and moves on to the output register once that is free or draining; one
//   beat per cycle sustained while the output is not stalled (one offset
//   memory read port feeds queries).
//   Tick: the offset memory is walked read-modify-write, one column a cycle,
//   then the drain state writes back the last column and stages the result;
//   input is held off meanwhile. A tick with zero steps or zero columns
//   passes straight through like a query.
// Reset
//   Clears control and the seed chain; reloads config defaults. The offset
//   memory is not cleared: a column must be seeded before it is read.
// Stall
//   A stalled output holds its beat; one staged beat behind it is kept and
//   input stops until the output drains.
`timescale 1ns / 1ps
`default_nettype none

module column_melt_wipe_offsets_unit
  import cmw_pkg::*;
#(
  parameter int MAX_COLUMNS  = MAX_COLUMNS_DEF,
  parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // command beats
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [CMD_W-1:0]     cmd_i,
  input  wire logic [COL_W-1:0]     column_i,
  input  wire logic [ROW_W-1:0]     row_i,
  input  wire logic [RND_W-1:0]     random_byte_i,
  input  wire logic [TICK_W-1:0]    tick_count_i,
  // result beats
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic                      done_res_o,
  output logic                      from_end_o,
  output logic [ROW_W-1:0]          source_row_o,
  // config writes
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i
);

  localparam int AW  = $clog2(MAX_COLUMNS);      // memory address width
  localparam int NW  = $clog2(MAX_COLUMNS + 1);  // active column count width
  localparam int OW  = OFFSET_WIDTH;
  localparam int OWX = OFFSET_WIDTH + 1;         // headroom for offset math
  localparam int CW  = ((OW > ROW_W) ? OW : ROW_W) + 1;

  localparam logic [11:0] MaxColsX = 12'(MAX_COLUMNS);
  localparam logic [15:0] OfsMax   = 16'((1 << (OW - 1)) - 1);

  localparam logic signed [OWX-1:0] OneX     = OWX'(1);
  localparam logic signed [OWX-1:0] EightX   = OWX'(8);
  localparam logic signed [OWX-1:0] SixteenX = OWX'(16);
  localparam logic signed [OWX-1:0] ZeroX    = OWX'(0);
  localparam logic signed [OWX-1:0] SeedMinX = -OWX'(15);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [CFG_W-1:0] column_count_q, screen_height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_count_q  <= COLUMN_COUNT_RST;
      screen_height_q <= SCREEN_HEIGHT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_COLUMN_COUNT:  column_count_q  <= cfg_data_i;
        CFG_SCREEN_HEIGHT: screen_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Offset memory: one write port, one registered read port
  // ---------------------------------------------------------------------
  logic signed [OW-1:0] offset_mem [MAX_COLUMNS];
  logic                 mem_we, mem_re;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  logic signed [OW-1:0] mem_wdata;
  logic signed [OW-1:0] mem_rdata_q;
  logic                 fwd_q;
  logic signed [OW-1:0] fwd_data_q;
  logic signed [OW-1:0] rd_data;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      offset_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= offset_mem[mem_raddr];
      fwd_data_q  <= mem_wdata;
    end
  end

  // Same-entry read and write in one cycle: take the value being written.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (mem_re) begin
      fwd_q <= mem_we && (mem_waddr == mem_raddr);
    end
  end

  assign rd_data = fwd_q ? fwd_data_q : mem_rdata_q;

  // ---------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------
  state_e               state_q, state_d;
  logic [NW-1:0]        rd_col_q, rd_col_d;      // walk read pointer
  logic [NW-1:0]        n_q, n_d;                // active columns of this tick
  logic [OW-1:0]        h_q, h_d;                // melt height of this tick
  logic [TICK_W-1:0]    ticks_left_q, ticks_left_d;
  logic                 moved_q, moved_d;
  logic                 rmw_valid_q, rmw_valid_d;
  logic [AW-1:0]        rmw_addr_q, rmw_addr_d;
  logic signed [OW-1:0] last_seed_q, last_seed_d;

  // staged beat between acceptance and the output register
  logic                 s1_valid_q, s1_valid_d;
  logic                 s1_query_q, s1_query_d;
  logic                 s1_inrange_q, s1_inrange_d;
  logic [ROW_W-1:0]     s1_row_q, s1_row_d;
  logic                 s1_done_q, s1_done_d;
  logic                 s1_adv;

  logic                 out_valid_q;
  logic                 done_res_q, from_end_q;
  logic [ROW_W-1:0]     source_row_q;

  logic                 in_acc;

  // ---------------------------------------------------------------------
  // Decoded inputs
  // ---------------------------------------------------------------------
  logic [11:0]           col_x;
  logic                  col_inrange;
  logic [AW-1:0]         col_addr;
  logic [11:0]           cc_x, n_x;
  logic [NW-1:0]         n_eff;
  logic [15:0]           hgt_x, h_x;
  logic signed [OWX-1:0] nib_x, chain_x, seed_x;

  assign col_x       = {3'b000, column_i};
  assign col_inrange = col_x < MaxColsX;
  assign col_addr    = col_x[AW-1:0];

  // Columns beyond storage are never advanced.
  assign cc_x  = {2'b00, column_count_q};
  assign n_x   = (cc_x > MaxColsX) ? MaxColsX : cc_x;
  assign n_eff = n_x[NW-1:0];

  // Height limited to the largest positive offset.
  assign hgt_x = 16'(screen_height_q);
  assign h_x   = (hgt_x > OfsMax) ? OfsMax : hgt_x;

  // Seed chain: column 0 restarts it, later columns drift by -1, 0 or +1.
  always_comb begin
    nib_x   = signed'(OWX'(random_byte_i[3:0]));
    chain_x = OWX'(last_seed_q) + signed'(OWX'(mod3_byte(random_byte_i))) - OneX;
    if (column_i == '0) begin
      seed_x = -nib_x;
    end else if (chain_x > ZeroX) begin
      seed_x = ZeroX;
    end else if (chain_x < SeedMinX) begin
      seed_x = SeedMinX;
    end else begin
      seed_x = chain_x;
    end
  end

  // ---------------------------------------------------------------------
  // Melt step on the offset returning from memory
  // ---------------------------------------------------------------------
  logic signed [OWX-1:0] v_x, hh_x, dy_x, sum_x, grown_x, melt_x;
  logic                  v_neg, v_grow, step_moved;

  always_comb begin
    v_x     = OWX'(rd_data);
    hh_x    = signed'({1'b0, h_q});
    v_neg   = v_x < ZeroX;
    v_grow  = !v_neg && (v_x < hh_x);
    dy_x    = (v_x < SixteenX) ? (v_x + OneX) : EightX;
    sum_x   = v_x + dy_x;
    grown_x = (sum_x >= hh_x) ? hh_x : sum_x;
    if (v_neg) begin
      melt_x = v_x + OneX;
    end else if (v_grow) begin
      melt_x = grown_x;
    end else begin
      melt_x = v_x;
    end
    step_moved = v_neg || v_grow;
  end

  // ---------------------------------------------------------------------
  // Next state and datapath control
  // ---------------------------------------------------------------------
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = (state_q == ST_IDLE) && (!s1_valid_q || s1_adv);
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    state_d      = state_q;
    rd_col_d     = rd_col_q;
    n_d          = n_q;
    h_d          = h_q;
    ticks_left_d = ticks_left_q;
    moved_d      = moved_q;
    rmw_valid_d  = 1'b0;
    rmw_addr_d   = rmw_addr_q;
    last_seed_d  = last_seed_q;

    s1_valid_d   = s1_valid_q && !s1_adv;
    s1_query_d   = s1_query_q;
    s1_inrange_d = s1_inrange_q;
    s1_row_d     = s1_row_q;
    s1_done_d    = s1_done_q;

    mem_we    = 1'b0;
    mem_waddr = rmw_addr_q;
    mem_wdata = OW'(melt_x);
    mem_re    = 1'b0;
    mem_raddr = col_addr;

    // write back the column read last cycle
    if (rmw_valid_q) begin
      mem_we  = 1'b1;
      moved_d = moved_q || step_moved;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          // every beat except a long tick lands in the stage at once
          s1_valid_d   = 1'b1;
          s1_query_d   = 1'b0;
          s1_inrange_d = 1'b0;
          s1_row_d     = row_i;
          s1_done_d    = 1'b0;
          unique case (cmd_e'(cmd_i))
            CMD_SEED: begin
              if (col_inrange) begin
                mem_we      = 1'b1;
                mem_waddr   = col_addr;
                mem_wdata   = OW'(seed_x);
                last_seed_d = OW'(seed_x);
              end
            end
            CMD_TICK: begin
              n_d = n_eff;
              h_d = h_x[OW-1:0];
              if (tick_count_i == '0 || n_eff == '0) begin
                s1_done_d = 1'b1;
              end else begin
                s1_valid_d   = 1'b0;
                state_d      = ST_WALK;
                rd_col_d     = '0;
                ticks_left_d = tick_count_i;
                moved_d      = 1'b0;
              end
            end
            CMD_QUERY: begin
              mem_re       = 1'b1;
              s1_query_d   = 1'b1;
              s1_inrange_d = col_inrange;
            end
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        mem_re      = 1'b1;
        mem_raddr   = rd_col_q[AW-1:0];
        rmw_valid_d = 1'b1;
        rmw_addr_d  = rd_col_q[AW-1:0];
        if (rd_col_q == n_q - NW'(1)) begin
          rd_col_d     = '0;
          ticks_left_d = ticks_left_q - TICK_W'(1);
          if (ticks_left_q == TICK_W'(1)) begin
            state_d = ST_DRAIN;
          end
        end else begin
          rd_col_d = rd_col_q + NW'(1);
        end
      end
      ST_DRAIN: begin
        // last column writes back now; report whether anything moved
        s1_valid_d = 1'b1;
        s1_query_d = 1'b0;
        s1_done_d  = !moved_d;
        state_d    = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      rd_col_q     <= '0;
      n_q          <= '0;
      h_q          <= '0;
      ticks_left_q <= '0;
      moved_q      <= 1'b0;
      rmw_valid_q  <= 1'b0;
      rmw_addr_q   <= '0;
      last_seed_q  <= '0;
      s1_valid_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      rd_col_q     <= rd_col_d;
      n_q          <= n_d;
      h_q          <= h_d;
      ticks_left_q <= ticks_left_d;
      moved_q      <= moved_d;
      rmw_valid_q  <= rmw_valid_d;
      rmw_addr_q   <= rmw_addr_d;
      last_seed_q  <= last_seed_d;
      s1_valid_q   <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_query_q   <= s1_query_d;
    s1_inrange_q <= s1_inrange_d;
    s1_row_q     <= s1_row_d;
    s1_done_q    <= s1_done_d;
  end

  // ---------------------------------------------------------------------
  // Query resolve and output register
  // ---------------------------------------------------------------------
  logic [CW-1:0]    row_x, p_x;
  logic             res_from_end;
  logic [ROW_W-1:0] res_row;

  always_comb begin
    row_x = CW'(s1_row_q);
    p_x   = '0;
    if (s1_inrange_q && rd_data > OW'(0)) begin
      p_x = CW'(unsigned'(rd_data));
    end
    res_from_end = 1'b0;
    res_row      = '0;
    if (s1_query_q) begin
      res_from_end = row_x < p_x;
      res_row      = res_from_end ? s1_row_q : ROW_W'(row_x - p_x);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      done_res_q   <= s1_done_q;
      from_end_q   <= res_from_end;
      source_row_q <= res_row;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign done_res_o   = done_res_q;
  assign from_end_o   = from_end_q;
  assign source_row_o = source_row_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // A tick walk must own the read port: nothing may sit in the stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK || state_q == ST_DRAIN) |-> !s1_valid_q)
    else $error("staged beat present during tick walk");

  // The drain cycle always carries the final write-back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |-> rmw_valid_q)
    else $error("drain without pending write-back");

  // Write-back only happens inside a walk.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rmw_valid_q |-> (state_q == ST_WALK || state_q == ST_DRAIN))
    else $error("write-back outside tick walk");

  // A non-trivial tick holds input off until its result is staged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |=> (s1_valid_q && !s1_query_q && state_q == ST_IDLE))
    else $error("tick result not staged after drain");

endmodule

`default_nettype wire

FILE: test/tb_column_melt_wipe_offsets_unit.sv
// Self-checking testbench for column_melt_wipe_offsets_unit: seed/tick/query beats
// are predicted in SystemVerilog and compared against the result channel.
// Depends on cmw_pkg and column_melt_wipe_offsets_unit.
`timescale 1ns / 1ps
`default_nettype none

module tb_column_melt_wipe_offsets_unit;
  import cmw_pkg::*;

  localparam int MAX_COLS    = MAX_COLUMNS_DEF;
  localparam int OFS_W       = OFFSET_WIDTH_DEF;
  localparam int OFS_LIMIT   = 2 ** (OFS_W - 1) - 1;
  localparam int ITEM_TARGET = 1050;
  localparam int PRINT_CAP   = 100;
  // The one command code the package leaves unnamed; the block must answer it with zeros.
  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

  typedef struct packed {
    logic            done;
    logic            fe;
    logic [ROW_W-1:0] src;
  } melt_result_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [RND_W-1:0]  rnd;
    logic [TICK_W-1:0] tc;
    bit                typed;
    melt_result_t      want;
  } stim_row_t;

  typedef enum logic [1:0] {
    SINK_OPEN,
    SINK_HALF,
    SINK_TIGHT
  } sink_mode_e;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT pins; every input starts at a known value.
  // ---------------------------------------------------------------------------
  logic                 clk         = 1'b0;
  logic                 rst_n       = 1'b0;
  logic                 in_valid    = 1'b0;
  logic [CMD_W-1:0]     cmd         = '0;
  logic [COL_W-1:0]     column      = '0;
  logic [ROW_W-1:0]     row         = '0;
  logic [RND_W-1:0]     random_byte = '0;
  logic [TICK_W-1:0]    tick_count  = '0;
  logic                 out_ready   = 1'b0;
  logic                 cfg_valid   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index   = CFG_COLUMN_COUNT;
  logic [CFG_W-1:0]     cfg_data    = '0;

  wire logic             in_ready;
  wire logic             out_valid;
  wire logic             done_res;
  wire logic             from_end;
  wire logic [ROW_W-1:0] source_row;
  wire logic             cfg_ready;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  column_melt_wipe_offsets_unit u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .cmd_i         (cmd),
    .column_i      (column),
    .row_i         (row),
    .random_byte_i (random_byte),
    .tick_count_i  (tick_count),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .done_res_o    (done_res),
    .from_end_o    (from_end),
    .source_row_o  (source_row),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Melt predictor: private copy of the offsets, the seed chain and the config.
  // ---------------------------------------------------------------------------
  logic signed [OFS_W-1:0] col_ofs [MAX_COLS];
  bit                      col_seeded [MAX_COLS];
  logic signed [OFS_W-1:0] seed_chain  = '0;
  logic [CFG_W-1:0]        cur_columns = COLUMN_COUNT_RST;
  logic [CFG_W-1:0]        cur_height  = SCREEN_HEIGHT_RST;

  melt_result_t pending_results [$];
  stim_row_t    directed_rows [$];
  melt_result_t oldest;

  int     mismatches      = 0;
  int     results_checked = 0;
  int     items_sent      = 0;
  int     burst_left      = 0;
  int     stall_left      = 0;
  sink_mode_e sink_mode   = SINK_OPEN;
  longint cycle_count     = 0;
  longint cycle_limit     = 20000;

  function automatic int active_columns();
    return (cur_columns > MAX_COLS) ? MAX_COLS : int'(cur_columns);
  endfunction

  function automatic melt_result_t predict_melt_result(logic [CMD_W-1:0] c,
      logic [COL_W-1:0] col, logic [ROW_W-1:0] r, logic [RND_W-1:0] b,
      logic [TICK_W-1:0] tc);
    melt_result_t res;
    int v, h, n, dy, p;
    bit moved;
    res   = '0;
    moved = 1'b0;
    if (c == CMD_SEED) begin
      // Column 0 starts a new chain; every other column walks from the last seed.
      if (col == 0) begin
        v = -int'(b % 16);
      end else begin
        v = int'(seed_chain) + int'(b % 3) - 1;
        if (v > 0) v = 0;
        else if (v < -15) v = -15;
      end
      col_ofs[col]    = OFS_W'(v);
      col_seeded[col] = 1'b1;
      seed_chain      = OFS_W'(v);
    end else if (c == CMD_TICK) begin
      h = (cur_height > OFS_LIMIT) ? OFS_LIMIT : int'(cur_height);
      n = active_columns();
      for (int t = 0; t < tc; t++) begin
        for (int k = 0; k < n; k++) begin
          v = col_ofs[k];
          if (v < 0) begin
            col_ofs[k] = OFS_W'(v + 1);
            moved = 1'b1;
          end else if (v < h) begin
            dy = (v < 16) ? v + 1 : 8;
            if (v + dy >= h) dy = h - v;
            col_ofs[k] = OFS_W'(v + dy);
            moved = 1'b1;
          end
        end
      end
      res.done = !moved;
    end else if (c == CMD_QUERY) begin
      v = col_ofs[col];
      p = (v > 0) ? v : 0;
      if (int'(r) < p) begin
        res.fe  = 1'b1;
        res.src = r;
      end else begin
        res.src = ROW_W'(int'(r) - p);
      end
    end
    return res;
  endfunction

  function automatic int first_unseeded();
    for (int k = 0; k < MAX_COLS; k++) begin
      if (!col_seeded[k]) return k;
    end
    return MAX_COLS;
  endfunction

  // Never query a column that was never seeded: its offset is undefined.
  function automatic logic [COL_W-1:0] pick_seeded_column();
    int col;
    col = $urandom_range(0, MAX_COLS - 1);
    if (!col_seeded[col]) col = $urandom_range(0, first_unseeded() - 1);
    return COL_W'(col);
  endfunction

  // Mostly rows on the screen, now and then anything the field allows.
  function automatic logic [ROW_W-1:0] query_row(int h);
    int lim;
    lim = (h + 20 > 1023) ? 1023 : h + 20;
    if ($urandom_range(0, 3) == 0) return ROW_W'($urandom_range(0, 1023));
    return ROW_W'($urandom_range(0, lim));
  endfunction

  function automatic void add_row(logic [CMD_W-1:0] c, int col, int r, int b, int tc,
      bit typed, bit d = 1'b0, bit f = 1'b0, int s = 0);
    stim_row_t sr;
    sr.cmd       = c;
    sr.col       = COL_W'(col);
    sr.row       = ROW_W'(r);
    sr.rnd       = RND_W'(b);
    sr.tc        = TICK_W'(tc);
    sr.typed     = typed;
    sr.want.done = d;
    sr.want.fe   = f;
    sr.want.src  = ROW_W'(s);
    directed_rows.push_back(sr);
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < PRINT_CAP) $display("MISMATCH at result %0d: %s", results_checked, msg);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Command side. Every task is entered right after a rising edge.
  // ---------------------------------------------------------------------------
  task automatic send_beat(logic [CMD_W-1:0] c, logic [COL_W-1:0] col,
      logic [ROW_W-1:0] r, logic [RND_W-1:0] b, logic [TICK_W-1:0] tc,
      bit typed = 1'b0, melt_result_t want = '0);
    melt_result_t res;
    int cost;
    in_valid    <= 1'b1;
    cmd         <= c;
    column      <= col;
    row         <= r;
    random_byte <= b;
    tick_count  <= tc;
    do begin
      @(posedge clk);
    end while (!in_ready);
    // Beat taken at this edge: predict now, in acceptance order.
    cost = (c == CMD_TICK) ? active_columns() * int'(tc) + 2 : 2;
    res  = predict_melt_result(c, col, r, b, tc);
    pending_results.push_back(typed ? want : res);
    items_sent++;
    cycle_limit += 4 * (cost + 8 + 64);
    // Bursts: drop valid for a short gap once the burst runs out.
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(0, 12);
    end
  endtask

  // Hold off input until every pending result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (pending_results.size() != 0);
  endtask

  // Write both registers back to back; valid stays high between the two beats.
  task automatic write_config(logic [CFG_W-1:0] cols, logic [CFG_W-1:0] height);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_COLUMN_COUNT;
    cfg_data  <= cols;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    cur_columns = cols;
    cfg_index <= CFG_SCREEN_HEIGHT;
    cfg_data  <= height;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    cur_height = height;
    cfg_valid <= 1'b0;
    cycle_limit += 64;
  endtask

  // One melt: optional config, reseed a prefix of columns in order (the normal
  // wipe start), then a mix of ticks and queries with some noise.
  task automatic run_melt_phase(int cols, int height, bit do_cfg, int reseed_n,
      int mixed_n);
    int pick;
    logic [TICK_W-1:0] tc;
    wait_drained();
    if (do_cfg) write_config(CFG_W'(cols), CFG_W'(height));
    for (int k = 0; k < reseed_n; k++) begin
      send_beat(CMD_SEED, COL_W'(k), query_row(height), RND_W'($urandom_range(0, 255)),
                TICK_W'($urandom_range(0, 15)));
      if ($urandom_range(0, 4) == 0)
        send_beat(CMD_QUERY, pick_seeded_column(), query_row(height),
                  RND_W'($urandom_range(0, 255)), TICK_W'($urandom_range(0, 15)));
    end
    for (int i = 0; i < mixed_n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        send_beat(CMD_QUERY, pick_seeded_column(), query_row(height),
                  RND_W'($urandom_range(0, 255)), TICK_W'($urandom_range(0, 15)));
      end else if (pick < 70) begin
        // Advance only when every active column holds a seeded offset.
        tc = (first_unseeded() >= active_columns() && $urandom_range(0, 9) != 0)
             ? TICK_W'($urandom_range(1, 15)) : '0;
        send_beat(CMD_TICK, COL_W'($urandom_range(0, 511)), ROW_W'($urandom_range(0, 1023)),
                  RND_W'($urandom_range(0, 255)), tc);
      end else if (pick < 80) begin
        send_beat(CMD_SEED, COL_W'($urandom_range(0, 511)), ROW_W'($urandom_range(0, 1023)),
                  RND_W'($urandom_range(0, 255)), TICK_W'($urandom_range(0, 15)));
      end else if (pick < 86) begin
        send_beat(CMD_UNKNOWN, COL_W'($urandom_range(0, 511)),
                  ROW_W'($urandom_range(0, 1023)), RND_W'($urandom_range(0, 255)),
                  TICK_W'($urandom_range(0, 15)));
      end else begin
        send_beat(CMD_QUERY, pick_seeded_column(), ROW_W'($urandom_range(0, 1023)),
                  RND_W'($urandom_range(0, 255)), TICK_W'($urandom_range(0, 15)));
      end
      if ($urandom_range(0, 59) == 0) wait_drained();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: check each beat against the oldest prediction, then pick the
  // next ready value from the current stall pattern.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing pending (done %0b end %0b row %0d)",
                                  done_res, from_end, source_row));
      end else begin
        oldest = pending_results.pop_front();
        if (done_res !== oldest.done)
          report_mismatch($sformatf("done_res %0b, expected %0b", done_res, oldest.done));
        if (from_end !== oldest.fe)
          report_mismatch($sformatf("from_end %0b, expected %0b", from_end, oldest.fe));
        if (source_row !== oldest.src)
          report_mismatch($sformatf("source_row %0d, expected %0d", source_row, oldest.src));
      end
      results_checked++;
    end
    if (stall_left == 0) begin
      sink_mode  = sink_mode_e'($urandom_range(0, 2));
      stall_left = $urandom_range(20, 200);
    end else begin
      stall_left--;
    end
    case (sink_mode)
      SINK_OPEN: out_ready <= 1'b1;
      SINK_HALF: out_ready <= ($urandom_range(0, 1) == 0);
      default:   out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Watchdog: the limit grows with the worst-case cost of every beat sent.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > cycle_limit) begin
      $display("TIMEOUT after %0d cycles, %0d results pending", cycle_count,
               pending_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int cols, height, n, reseed_n;
    // Directed beats under the reset config. Results typed in here are plain zeros
    // (seeds, unknown command), done on zero steps, or rows passed straight through.
    add_row(CMD_SEED, 0, 0, 0, 0, 1'b1);                       // column 0, offset 0
    add_row(CMD_QUERY, 0, 0, 0, 0, 1'b1, 1'b0, 1'b0, 0);
    add_row(CMD_QUERY, 0, 1023, 255, 15, 1'b1, 1'b0, 1'b0, 1023);
    add_row(CMD_UNKNOWN, 511, 1023, 255, 15, 1'b1);            // unknown command: zeros
    add_row(CMD_TICK, 511, 1023, 255, 0, 1'b1, 1'b1);          // zero steps: done
    add_row(CMD_SEED, 0, 1023, 255, 15, 1'b1);                 // deepest start offset
    add_row(CMD_SEED, 1, 0, 0, 0, 1'b0);                       // chain clamps at the bottom
    add_row(CMD_SEED, 2, 0, 2, 0, 1'b0);
    add_row(CMD_SEED, 511, 0, 255, 0, 1'b0);                   // last column, out of order
    add_row(CMD_QUERY, 511, 0, 0, 0, 1'b1, 1'b0, 1'b0, 0);
    add_row(CMD_QUERY, 511, 1023, 0, 0, 1'b1, 1'b0, 1'b0, 1023);
    add_row(CMD_SEED, 7, 512, 1, 8, 1'b0);                     // skips columns 3..6
    add_row(CMD_SEED, 0, 0, 16, 0, 1'b0);                      // restart chain at 0
    add_row(CMD_SEED, 3, 0, 2, 0, 1'b0);                       // chain clamps at the top
    add_row(CMD_SEED, 4, 0, 254, 0, 1'b0);
    add_row(CMD_QUERY, 3, 512, 0, 0, 1'b1, 1'b0, 1'b0, 512);
    add_row(CMD_QUERY, 2, 1, 0, 0, 1'b0);
    add_row(CMD_SEED, 5, 0, 128, 0, 1'b0);
    add_row(CMD_TICK, 0, 0, 0, 0, 1'b1, 1'b1);
    add_row(CMD_QUERY, 4, 1022, 0, 0, 1'b1, 1'b0, 1'b0, 1022);
    add_row(CMD_SEED, 6, 0, 3, 0, 1'b0);
    add_row(CMD_QUERY, 6, 700, 0, 0, 1'b0);
    add_row(CMD_QUERY, 7, 0, 0, 0, 1'b0);

    // Hold reset, then release it at an edge.
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_beat(directed_rows[i].cmd, directed_rows[i].col, directed_rows[i].row,
                directed_rows[i].rnd, directed_rows[i].tc, directed_rows[i].typed,
                directed_rows[i].want);
    end

    // Whole-screen wipe with the reset config: seed every column, then melt.
    run_melt_phase(int'(COLUMN_COUNT_RST), int'(SCREEN_HEIGHT_RST), 1'b0, MAX_COLS, 80);
    // Config extremes and the odd corners.
    run_melt_phase(1, 1, 1'b1, 1, 25);
    run_melt_phase(512, 1023, 1'b1, 64, 30);
    run_melt_phase(1023, 0, 1'b1, 32, 25);     // too many columns, zero height
    run_melt_phase(0, 1, 1'b1, 0, 15);         // nothing active: every tick done
    run_melt_phase(16, 1023, 1'b1, 16, 30);
    run_melt_phase(16, 6, 1'b1, 0, 20);        // height lowered mid-melt, no reseed

    // Random melts until the item count is reached.
    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 7))
        0:       cols = $urandom_range(513, 1023);
        1:       cols = 512;
        2:       cols = $urandom_range(0, 1);
        default: cols = $urandom_range(2, 64);
      endcase
      case ($urandom_range(0, 7))
        0:       height = 0;
        1:       height = 1023;
        2:       height = $urandom_range(64, 1022);
        default: height = $urandom_range(1, 48);
      endcase
      n = (cols > MAX_COLS) ? MAX_COLS : cols;
      reseed_n = ($urandom_range(0, 2) != 0) ? ((n > 64) ? 64 : n) : 0;
      run_melt_phase(cols, height, 1'b1, reseed_n, $urandom_range(20, 50));
    end

    // Drain, let the pipeline settle, then give the verdict.
    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
design/cmw_pkg.sv
design/column_melt_wipe_offsets_unit.sv
test/tb_column_melt_wipe_offsets_unit.sv
